[design/mhq_pkg.sv]
// Shared types, constants and arctangent table for the heading/quaternion pipeline.
`timescale 1ns / 1ps

package mhq_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int ANGLE_STAGES = 16;
   localparam int TABLE_LEN    = 24;
   localparam int N_STAGES     = (ANGLE_STAGES < TABLE_LEN) ? ANGLE_STAGES : TABLE_LEN;
   localparam int IDX_W        = $clog2(TABLE_LEN);

   // samples are lifted to a 2^39 full scale; CORDIC gain needs headroom above that
   localparam int XY_W     = 43;
   localparam int SCALE_SH = 40 - SAMPLE_WIDTH;
   localparam int ANG_W    = 34;
   localparam int CS_W     = 33;

   localparam int HEADING_W = 16;
   localparam int QZ_W      = 16;
   localparam int QW_W      = 15;

   localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(32'sh40000000);
   localparam logic signed [CS_W-1:0]  INV_GAIN     = CS_W'(32'sd652032874);
   localparam logic [QW_W-1:0]         QUAT_ONE     = QW_W'(16384);

   localparam logic signed [ANG_W-1:0] ATAN_TAB [TABLE_LEN] = '{
      ANG_W'(32'sh20000000), ANG_W'(32'sh12E4051E), ANG_W'(32'sh09FB385B),
      ANG_W'(32'sh051111D4), ANG_W'(32'sh028B0D43), ANG_W'(32'sh0145D7E1),
      ANG_W'(32'sh00A2F61E), ANG_W'(32'sh00517C55), ANG_W'(32'sh0028BE53),
      ANG_W'(32'sh00145F2F), ANG_W'(32'sh000A2F98), ANG_W'(32'sh000517CC),
      ANG_W'(32'sh00028BE6), ANG_W'(32'sh000145F3), ANG_W'(32'sh0000A2FA),
      ANG_W'(32'sh0000517D), ANG_W'(32'sh000028BE), ANG_W'(32'sh0000145F),
      ANG_W'(32'sh00000A2F), ANG_W'(32'sh00000517), ANG_W'(32'sh0000028B),
      ANG_W'(32'sh00000145), ANG_W'(32'sh000000A2), ANG_W'(32'sh00000051)
   };

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] field_x;
      logic signed [SAMPLE_WIDTH-1:0] field_y;
   } req_payload_type;

   typedef struct packed {
      logic signed [HEADING_W-1:0] heading;
      logic signed [QZ_W-1:0]      quat_z;
      logic [QW_W-1:0]             quat_w;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
      logic signed [ANG_W-1:0] ang;
      logic                    zero;
   } vec_data_type;

   typedef struct packed {
      logic signed [CS_W-1:0]      c;
      logic signed [CS_W-1:0]      s;
      logic signed [ANG_W-1:0]     r;
      logic signed [HEADING_W-1:0] heading;
      logic                        zero;
   } rot_data_type;

   function automatic logic signed [ANG_W-1:0] atan_entry(input logic [IDX_W-1:0] idx);
      logic signed [ANG_W-1:0] val;
      val = '0;
      if (32'(idx) < TABLE_LEN) begin
         val = ATAN_TAB[idx];
      end
      return val;
   endfunction

endpackage

[design/mhq_vector_cell.sv]
// One vectoring CORDIC cell: turns (x, y) toward the x axis and accumulates the angle.
`timescale 1ns / 1ps

module mhq_vector_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [mhq_pkg::IDX_W-1:0]  stage_idx,
   input  logic                       in_valid,
   input  mhq_pkg::vec_data_type      in_data,
   input  logic                       advance,
   output logic                       valid_ff,
   output mhq_pkg::vec_data_type      data_ff
);
   import mhq_pkg::*;

   logic                    valid_in;
   vec_data_type            data_in;
   logic signed [XY_W-1:0]  dx;
   logic signed [XY_W-1:0]  dy;
   logic signed [ANG_W-1:0] step;

   always_comb begin
      dx      = in_data.y >>> stage_idx;
      dy      = in_data.x >>> stage_idx;
      step    = atan_entry(stage_idx);
      data_in = in_data;
      if (!in_data.y[XY_W-1]) begin
         data_in.x   = in_data.x + dx;
         data_in.y   = in_data.y - dy;
         data_in.ang = in_data.ang + step;
      end else begin
         data_in.x   = in_data.x - dx;
         data_in.y   = in_data.y + dy;
         data_in.ang = in_data.ang - step;
      end
      valid_in = advance ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

endmodule

[design/mhq_rotate_cell.sv]
// One rotation CORDIC cell: turns (cos, sin) by the next table angle toward the residual.
`timescale 1ns / 1ps

module mhq_rotate_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [mhq_pkg::IDX_W-1:0]  stage_idx,
   input  logic                       in_valid,
   input  mhq_pkg::rot_data_type      in_data,
   input  logic                       advance,
   output logic                       valid_ff,
   output mhq_pkg::rot_data_type      data_ff
);
   import mhq_pkg::*;

   logic                    valid_in;
   rot_data_type            data_in;
   logic signed [CS_W-1:0]  dc;
   logic signed [CS_W-1:0]  ds;
   logic signed [ANG_W-1:0] step;

   always_comb begin
      dc      = in_data.s >>> stage_idx;
      ds      = in_data.c >>> stage_idx;
      step    = atan_entry(stage_idx);
      data_in = in_data;
      if (!in_data.r[ANG_W-1]) begin
         data_in.c = in_data.c - dc;
         data_in.s = in_data.s + ds;
         data_in.r = in_data.r - step;
      end else begin
         data_in.c = in_data.c + dc;
         data_in.s = in_data.s - ds;
         data_in.r = in_data.r + step;
      end
      valid_in = advance ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

endmodule

[design/magnetometer_heading_quaternion.sv]
// Top level: magnetometer sample to heading and yaw-only quaternion.
`timescale 1ns / 1ps

// Takes one level magnetometer sample per cycle while req_stall is low and returns heading =
// atan2(y, x) in units of pi/32768 (saturating at +32767) plus z = sin(heading/2) and w =
// cos(heading/2) in Q1.14. The datapath is a row of CORDIC cells: a quarter-turn
// pre-rotation register, N_STAGES vectoring cells, N_STAGES rotation cells and an output
// register, and a new request is taken every cycle while req_stall is low. Each cell holds
// its own valid bit and loads whenever it is empty or the cell after it moves on, so empty
// slots close up while rsp is stalled and req_stall rises only once every register holds a
// request and rsp_stall is high. A zero vector returns heading 0, z 0 and w 1.0.
module magnetometer_heading_quaternion (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  mhq_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output mhq_pkg::rsp_payload_type rsp_data
);
   import mhq_pkg::*;

   // pre-rotation stage
   logic                   pre_valid_ff;
   logic                   pre_valid_in;
   vec_data_type           pre_data_ff;
   vec_data_type           pre_data_in;
   logic                   pre_adv;
   logic signed [XY_W-1:0] sx;
   logic signed [XY_W-1:0] sy;

   logic [N_STAGES-1:0]    vec_valid;
   vec_data_type           vec_data [N_STAGES];
   logic [N_STAGES-1:0]    vec_adv;

   logic [N_STAGES-1:0]    rot_valid;
   rot_data_type           rot_data [N_STAGES];
   logic [N_STAGES-1:0]    rot_adv;
   rot_data_type           rot_init;

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   rsp_payload_type        rsp_data_ff;
   rsp_payload_type        rsp_data_in;
   logic                   out_adv;

   logic signed [ANG_W:0]  head_sum;
   logic signed [ANG_W:0]  head_q;
   logic signed [CS_W:0]   c_sum;
   logic signed [CS_W:0]   s_sum;
   logic signed [CS_W:0]   c_q;
   logic signed [CS_W:0]   s_q;

   // ---- flow control: a slot loads when empty or when its successor moves ----
   assign out_adv   = !rsp_valid_ff || !rsp_stall;
   assign pre_adv   = !pre_valid_ff || vec_adv[0];
   assign req_stall = !pre_adv;

   // ---- pre-rotation: scale up and fold the left half-plane by a quarter turn ----
   always_comb begin
      sx = XY_W'(req_data.field_x) <<< SCALE_SH;
      sy = XY_W'(req_data.field_y) <<< SCALE_SH;
      pre_data_in.zero = (req_data.field_x == '0) && (req_data.field_y == '0);
      pre_data_in.x    = sx;
      pre_data_in.y    = sy;
      pre_data_in.ang  = '0;
      if (sx[XY_W-1]) begin
         if (!sy[XY_W-1]) begin
            pre_data_in.x   = sy;
            pre_data_in.y   = -sx;
            pre_data_in.ang = QUARTER_TURN;
         end else begin
            pre_data_in.x   = -sy;
            pre_data_in.y   = sx;
            pre_data_in.ang = -QUARTER_TURN;
         end
      end
      pre_valid_in = pre_adv ? req_valid : pre_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
      end else begin
         pre_valid_ff <= pre_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pre_adv) begin
         pre_data_ff <= pre_data_in;
      end
   end

   // ---- vectoring row ----
   for (genvar k = 0; k < N_STAGES; k++) begin : g_vec
      if (k == 0) begin : g_first
         mhq_vector_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .stage_idx (IDX_W'(k)),
            .in_valid  (pre_valid_ff),
            .in_data   (pre_data_ff),
            .advance   (vec_adv[k]),
            .valid_ff  (vec_valid[k]),
            .data_ff   (vec_data[k])
         );
      end else begin : g_next
         mhq_vector_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .stage_idx (IDX_W'(k)),
            .in_valid  (vec_valid[k-1]),
            .in_data   (vec_data[k-1]),
            .advance   (vec_adv[k]),
            .valid_ff  (vec_valid[k]),
            .data_ff   (vec_data[k])
         );
      end
      if (k == N_STAGES - 1) begin : g_last_adv
         assign vec_adv[k] = !vec_valid[k] || rot_adv[0];
      end else begin : g_mid_adv
         assign vec_adv[k] = !vec_valid[k] || vec_adv[k+1];
      end
   end

   // ---- heading rounding and half angle for the rotation row ----
   always_comb begin
      head_sum = (ANG_W+1)'(vec_data[N_STAGES-1].ang) + (ANG_W+1)'(32768);
      head_q   = head_sum >>> 16;
      rot_init.zero = vec_data[N_STAGES-1].zero;
      if (head_q > (ANG_W+1)'(32767)) begin
         rot_init.heading = HEADING_W'(32767);
      end else if (head_q < -(ANG_W+1)'(32768)) begin
         rot_init.heading = HEADING_W'(-32768);
      end else begin
         rot_init.heading = HEADING_W'(head_q);
      end
      rot_init.c = INV_GAIN;
      rot_init.s = '0;
      rot_init.r = vec_data[N_STAGES-1].ang >>> 1;
   end

   // ---- rotation row ----
   for (genvar k = 0; k < N_STAGES; k++) begin : g_rot
      if (k == 0) begin : g_first
         mhq_rotate_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .stage_idx (IDX_W'(k)),
            .in_valid  (vec_valid[N_STAGES-1]),
            .in_data   (rot_init),
            .advance   (rot_adv[k]),
            .valid_ff  (rot_valid[k]),
            .data_ff   (rot_data[k])
         );
      end else begin : g_next
         mhq_rotate_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .stage_idx (IDX_W'(k)),
            .in_valid  (rot_valid[k-1]),
            .in_data   (rot_data[k-1]),
            .advance   (rot_adv[k]),
            .valid_ff  (rot_valid[k]),
            .data_ff   (rot_data[k])
         );
      end
      if (k == N_STAGES - 1) begin : g_last_adv
         assign rot_adv[k] = !rot_valid[k] || out_adv;
      end else begin : g_mid_adv
         assign rot_adv[k] = !rot_valid[k] || rot_adv[k+1];
      end
   end

   // ---- output rounding, clamping and zero-vector override ----
   always_comb begin
      c_sum = (CS_W+1)'(rot_data[N_STAGES-1].c) + (CS_W+1)'(32768);
      s_sum = (CS_W+1)'(rot_data[N_STAGES-1].s) + (CS_W+1)'(32768);
      c_q   = c_sum >>> 16;
      s_q   = s_sum >>> 16;
      rsp_data_in.heading = rot_data[N_STAGES-1].heading;
      if (c_q > (CS_W+1)'(16384)) begin
         rsp_data_in.quat_w = QUAT_ONE;
      end else if (c_q[CS_W]) begin
         rsp_data_in.quat_w = '0;
      end else begin
         rsp_data_in.quat_w = QW_W'(c_q);
      end
      if (s_q > (CS_W+1)'(16384)) begin
         rsp_data_in.quat_z = QZ_W'(16384);
      end else if (s_q < -(CS_W+1)'(16384)) begin
         rsp_data_in.quat_z = QZ_W'(-16384);
      end else begin
         rsp_data_in.quat_z = QZ_W'(s_q);
      end
      if (rot_data[N_STAGES-1].zero) begin
         rsp_data_in.heading = '0;
         rsp_data_in.quat_z  = '0;
         rsp_data_in.quat_w  = QUAT_ONE;
      end
      rsp_valid_in = out_adv ? rot_valid[N_STAGES-1] : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---- assertions ----
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (pre_valid_ff && (&vec_valid) && (&rot_valid) && rsp_valid_ff && rsp_stall))
      else $error("request stalled while the pipeline still has an empty slot");

   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result valid after reset");

   a_quat_w_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.quat_w <= QUAT_ONE))
      else $error("quat_w above 1.0");

   a_quat_z_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_data_ff.quat_z <= QZ_W'(16384))
                        && (rsp_data_ff.quat_z >= QZ_W'(-16384))))
      else $error("quat_z outside +-1.0");

endmodule
